/* sv/cfss_pkg.sv */
// Shared types, constants and the case-fold function of the substring search.
package cfss_pkg;

   // Defaults for the top-level parameters
   localparam int NEEDLE_MAX_DEFAULT  = 16;
   localparam int OFFSET_BITS_DEFAULT = 16;

   // Fixed field widths
   localparam int BYTE_BITS       = 8;
   localparam int LEN_BITS        = 5;
   localparam int POS_BITS        = 16;
   localparam int NEEDLE_WORD_BITS = 64;
   localparam int CSR_INDEX_BITS  = 3;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOLD_MODE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LEN  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LOW  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_HIGH = 3'd3;

   // Fold mode codes
   localparam logic FOLD_ALPHA   = 1'b0;
   localparam logic FOLD_BRACKET = 1'b1;

   typedef struct packed {
      logic [BYTE_BITS-1:0] hay_byte;
      logic                 hay_last;
   } req_type;

   typedef struct packed {
      logic                match_found;
      logic [POS_BITS-1:0] match_position;
   } rsp_type;

   // Per-beat control shared by every compare cell
   typedef struct packed {
      logic advance;
      logic clear;
   } cell_ctrl_type;

   // A-Z always fold to lower case; [ \ ] fold to { | } in bracket mode
   function automatic logic [BYTE_BITS-1:0] fold_byte(input logic [BYTE_BITS-1:0] c,
                                                      input logic mode);
      logic [BYTE_BITS-1:0] folded;
      folded = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         folded = c + 8'd32;
      end else if (mode == FOLD_BRACKET && c >= 8'h5b && c <= 8'h5d) begin
         folded = c + 8'd32;
      end
      return folded;
   endfunction

endpackage

/* sv/cfss_cell.sv */
// One compare cell: holds one bit of the shift-and partial match vector.
module cfss_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  cfss_pkg::cell_ctrl_type             ctrl,
   input  logic                                fold_mode,
   input  logic [cfss_pkg::BYTE_BITS-1:0]      hay_folded,
   input  logic [cfss_pkg::BYTE_BITS-1:0]      needle_byte,
   input  logic                                in_use,
   input  logic                                prev_bit,
   output logic                                match_next,
   output logic                                match_bit
);

   logic match_bit_ff;
   logic match_bit_in;
   logic byte_eq;

   // Folded needle byte against folded haystack byte
   assign byte_eq    = (cfss_pkg::fold_byte(needle_byte, fold_mode) == hay_folded);
   assign match_next = prev_bit & in_use & byte_eq;

   always_comb begin
      match_bit_in = match_bit_ff;
      if (ctrl.clear) begin
         match_bit_in = 1'b0;
      end else if (ctrl.advance) begin
         match_bit_in = match_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_bit_ff <= 1'b0;
      end else begin
         match_bit_ff <= match_bit_in;
      end
   end

   assign match_bit = match_bit_ff;

endmodule

/* sv/cfss_rsp_buf.sv */
// Result output register with a skid stage behind it.
module cfss_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cfss_pkg::rsp_type in_data,
   output logic              in_full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfss_pkg::rsp_type rsp_data
);

   logic              out_valid_ff, out_valid_in;
   cfss_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   cfss_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              out_free;

   assign out_free = ~out_valid_ff | ~rsp_stall;

   // Skid drains into the output first; new beats land behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = in_valid;
            skid_data_in  = in_data;
         end else begin
            out_valid_in  = in_valid;
            out_data_in   = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_full   = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Skid only fills while the output register is occupied
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a beat ahead of the output register");

   // A stalled output beat stays put
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled result beat changed");

   // A beat offered while full would be lost
   assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !(skid_valid_ff && out_valid_ff && rsp_stall))
      else $error("result beat offered with no room");

endmodule

/* sv/case_fold_substring_search.sv */
// Result beats on rsp_ come from the output register, via the skid stage if it is busy.
// Throughput: one byte per cycle unless req_stall; cell row advances on accepted beats.
// req_stall rises only when the result output and its skid stage are both full.
// Synchronous reset clears the registers (fold mode, length, needle) and the search state.
// No clearing pass after reset: the block takes bytes on the first cycle out of reset.
module case_fold_substring_search #(
   parameter int NEEDLE_MAX  = cfss_pkg::NEEDLE_MAX_DEFAULT,
   parameter int OFFSET_BITS = cfss_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  cfss_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output cfss_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cfss_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cfss_pkg::NEEDLE_WORD_BITS-1:0] csr_data
);

   localparam int LenW = $clog2(NEEDLE_MAX + 1);
   localparam int IdxW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
   localparam int PosW = (OFFSET_BITS > cfss_pkg::POS_BITS) ? OFFSET_BITS
                                                              : cfss_pkg::POS_BITS;
   localparam int WordW = cfss_pkg::NEEDLE_WORD_BITS;
   localparam int BW    = cfss_pkg::BYTE_BITS;

   // Configuration registers
   logic                          fold_mode_ff;
   logic [cfss_pkg::LEN_BITS-1:0] needle_length_ff;
   logic [WordW-1:0]              needle_low_ff;
   logic [WordW-1:0]              needle_high_ff;
   logic                          csr_write;

   // Search state
   logic [OFFSET_BITS-1:0] byte_offset_ff, byte_offset_in;
   logic                   finished_ff, finished_in;

   logic [2*WordW-1:0]     needle_all;
   logic [LenW-1:0]        len_eff;
   logic [LenW-1:0]        len_m1;
   logic [IdxW-1:0]        len_idx;
   logic                   len_zero;
   logic [BW-1:0]          hay_folded;
   logic                   accept;
   logic                   hit;
   logic                   result_valid;
   cfss_pkg::rsp_type      result;
   logic [PosW-1:0]        start_ext;
   logic                   buf_full;
   cfss_pkg::cell_ctrl_type cell_ctrl;
   logic [NEEDLE_MAX-1:0]  match_vec;
   logic [NEEDLE_MAX-1:0]  match_vec_next;

   // Register writes
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_mode_ff     <= cfss_pkg::FOLD_ALPHA;
         needle_length_ff <= '0;
         needle_low_ff    <= '0;
         needle_high_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            cfss_pkg::CSR_FOLD_MODE:   fold_mode_ff     <= csr_data[0];
            cfss_pkg::CSR_NEEDLE_LEN:  needle_length_ff <= csr_data[cfss_pkg::LEN_BITS-1:0];
            cfss_pkg::CSR_NEEDLE_LOW:  needle_low_ff    <= csr_data;
            cfss_pkg::CSR_NEEDLE_HIGH: needle_high_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Active length, clamped to the cell count
   always_comb begin
      if (needle_length_ff > cfss_pkg::LEN_BITS'(NEEDLE_MAX)) begin
         len_eff = LenW'(NEEDLE_MAX);
      end else begin
         len_eff = needle_length_ff[LenW-1:0];
      end
   end

   assign len_zero   = (len_eff == '0);
   assign len_m1     = len_eff - LenW'(1);
   assign len_idx    = len_m1[IdxW-1:0];
   assign needle_all = {needle_high_ff, needle_low_ff};
   assign hay_folded = cfss_pkg::fold_byte(req_data.hay_byte, fold_mode_ff);
   assign accept     = req_valid & ~req_stall;
   assign req_stall  = buf_full;

   assign cell_ctrl.advance = accept & ~finished_ff & ~len_zero;
   assign cell_ctrl.clear   = accept & req_data.hay_last;

   // Row of compare cells; each takes its left neighbor's stored bit
   for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_cell
      logic prev_bit;
      if (i == 0) begin : g_head
         assign prev_bit = 1'b1;
      end else begin : g_body
         assign prev_bit = match_vec[i-1];
      end
      cfss_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .fold_mode   (fold_mode_ff),
         .hay_folded  (hay_folded),
         .needle_byte (needle_all[BW*i +: BW]),
         .in_use      (len_eff > LenW'(i)),
         .prev_bit    (prev_bit),
         .match_next  (match_vec_next[i]),
         .match_bit   (match_vec[i])
      );
   end

   // Match completes when the cell at the needle's last byte fires
   assign hit = ~finished_ff & (len_zero | match_vec_next[len_idx]);
   assign start_ext = PosW'(byte_offset_ff) - PosW'(len_m1);

   always_comb begin
      result_valid          = accept & ~finished_ff & (hit | req_data.hay_last);
      result.match_found    = hit;
      result.match_position = '0;
      if (hit && !len_zero) begin
         result.match_position = start_ext[cfss_pkg::POS_BITS-1:0];
      end
   end

   // Offset saturates; last byte restarts the haystack
   always_comb begin
      byte_offset_in = byte_offset_ff;
      finished_in    = finished_ff;
      if (accept) begin
         if (req_data.hay_last) begin
            byte_offset_in = '0;
            finished_in    = 1'b0;
         end else begin
            if (byte_offset_ff != '1) begin
               byte_offset_in = byte_offset_ff + OFFSET_BITS'(1);
            end
            if (hit) begin
               finished_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff <= '0;
         finished_ff    <= 1'b0;
      end else begin
         byte_offset_ff <= byte_offset_in;
         finished_ff    <= finished_in;
      end
   end

   cfss_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result_valid),
      .in_data   (result),
      .in_full   (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A not-found beat only comes with the last byte
   assert property (@(posedge clock) disable iff (reset)
      result_valid && !result.match_found |-> req_data.hay_last)
      else $error("not-found result before end of haystack");

   // Nothing more for a haystack once its match was reported
   assert property (@(posedge clock) disable iff (reset)
      finished_ff && accept |-> !result_valid)
      else $error("second result for one haystack");

   // A match mid-haystack marks the search done
   assert property (@(posedge clock) disable iff (reset)
      result_valid && result.match_found && !req_data.hay_last |=> finished_ff)
      else $error("match did not finish the search");

   // Last byte restarts offset and match vector
   assert property (@(posedge clock) disable iff (reset)
      accept && req_data.hay_last |=> byte_offset_ff == '0 && match_vec == '0)
      else $error("search state not cleared after last byte");

endmodule
